// ===== hw/rtl/csq_pkg.sv =====
// csq_pkg: shared constants, types and helpers of the cursor sequence store
// used by the interfaces, the storage cell and the top level; depends on nothing
`default_nettype none

package csq_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;

  // count and cursor reach CAPACITY itself, cell index stays below it
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  // port field widths
  localparam int KIND_W  = 3;
  localparam int WORD_W  = 32;
  localparam int TOTAL_W = 5;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       count_t;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    K_START   = 3'd0,
    K_ADVANCE = 3'd1,
    K_INSERT  = 3'd2,
    K_ATTACH  = 3'd3,
    K_REMOVE  = 3'd4
  } kind_t;

  // what one cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_BELOW,
    CELL_FROM_ABOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    value_t   load_value;
  } cell_cmd_t;

  // port word to stored value, keeping the low VALUE_WIDTH bits
  function automatic value_t word_to_value(input logic [WORD_W-1:0] w);
    logic [63:0] wide;
    wide = 64'(w);
    return wide[VALUE_WIDTH-1:0];
  endfunction

  // stored value to port word, zero extended or truncated
  function automatic logic [WORD_W-1:0] value_to_word(input value_t v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[WORD_W-1:0];
  endfunction

  // item count to the port field
  function automatic logic [TOTAL_W-1:0] count_to_total(input count_t c);
    logic [31:0] wide;
    wide = 32'(c);
    return wide[TOTAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csq_req_if.sv =====
// csq_req_if: request channel of the cursor sequence store
// valid/ready handshake with operation kind and entry value; uses csq_pkg
`default_nettype none

interface csq_req_if;
  logic                         valid;
  logic                         ready;
  logic [csq_pkg::KIND_W-1:0]   kind;
  logic [csq_pkg::WORD_W-1:0]   entry_value;

  modport source (output valid, output kind, output entry_value, input ready);
  modport sink   (input valid, input kind, input entry_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/csq_rsp_if.sv =====
// csq_rsp_if: result channel of the cursor sequence store
// valid/ready handshake with current value, flags and item count; uses csq_pkg
`default_nettype none

interface csq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [csq_pkg::WORD_W-1:0]    current_value;
  logic                          has_current;
  logic [csq_pkg::TOTAL_W-1:0]   item_total;
  logic                          rejected;

  modport source (output valid, output current_value, output has_current,
                  output item_total, output rejected, input ready);
  modport sink   (input valid, input current_value, input has_current,
                  input item_total, input rejected, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cursor_sequence_store_top.sv =====
// cursor_sequence_store_top: bounded ordered list with a cursor, built as a row of cells
// depends on csq_pkg, csq_req_if, csq_rsp_if and csq_cell
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   kind[2:0], entry_value[31:0]
//   rsp      out  valid/ready   current_value[31:0], has_current, item_total[4:0], rejected
//
// one transaction per cycle while rsp does not stall: every cell shifts, loads or holds in parallel at the
// accepting edge, and the result is valid the cycle after.
// the result is read from the count, cursor and cell registers, held while rsp stalls;
// req.ready is high whenever no result waits or the waiting one is taken this cycle.
// reset (rst, synchronous) empties the list and puts the cursor at zero.
`default_nettype none

module cursor_sequence_store_top (
  input  wire logic clk,
  input  wire logic rst,
  csq_req_if.sink   req,
  csq_rsp_if.source rsp
);

  csq_pkg::count_t    count, count_next;
  csq_pkg::count_t    cursor, cursor_next;
  logic               rejected, rejected_next;
  logic               rsp_valid;
  logic               accept;
  logic               on_item;
  logic               full;
  logic               place;
  csq_pkg::count_t    place_pos;
  csq_pkg::value_t    new_value;
  csq_pkg::value_t    cell_value [csq_pkg::CAPACITY];
  csq_pkg::cell_cmd_t cell_cmd   [csq_pkg::CAPACITY];
  logic               remove_go;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign on_item   = cursor < count;
  assign full      = count == csq_pkg::count_t'(csq_pkg::CAPACITY);
  assign new_value = csq_pkg::word_to_value(req.entry_value);

  // operation decode: next count, cursor and placement
  always_comb begin
    count_next    = count;
    cursor_next   = cursor;
    rejected_next = 1'b0;
    place         = 1'b0;
    place_pos     = '0;
    remove_go     = 1'b0;
    unique case (req.kind)
      csq_pkg::K_START: begin
        cursor_next = '0;
      end
      csq_pkg::K_ADVANCE: begin
        if (on_item) begin
          cursor_next = cursor + 1'b1;
        end
      end
      csq_pkg::K_INSERT: begin
        if (full) begin
          rejected_next = 1'b1;
        end else begin
          place     = 1'b1;
          place_pos = on_item ? cursor : '0;
        end
      end
      csq_pkg::K_ATTACH: begin
        if (full) begin
          rejected_next = 1'b1;
        end else begin
          place     = 1'b1;
          place_pos = on_item ? cursor + 1'b1 : count;
        end
      end
      csq_pkg::K_REMOVE: begin
        if (on_item) begin
          remove_go  = 1'b1;
          count_next = count - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (place) begin
      count_next  = count + 1'b1;
      cursor_next = place_pos;
    end
  end

  // per-cell command: open a gap above the placement or close it from the cursor on
  always_comb begin
    for (int i = 0; i < csq_pkg::CAPACITY; i++) begin
      cell_cmd[i].load_value = new_value;
      cell_cmd[i].op         = csq_pkg::CELL_HOLD;
      if (accept && place) begin
        if (csq_pkg::count_t'(i) == place_pos) begin
          cell_cmd[i].op = csq_pkg::CELL_LOAD;
        end else if (csq_pkg::count_t'(i) > place_pos) begin
          cell_cmd[i].op = csq_pkg::CELL_FROM_BELOW;
        end
      end else if (accept && remove_go) begin
        if (csq_pkg::count_t'(i) >= cursor) begin
          cell_cmd[i].op = csq_pkg::CELL_FROM_ABOVE;
        end
      end
    end
  end

  // row of cells, each wired to its two neighbors
  for (genvar g = 0; g < csq_pkg::CAPACITY; g++) begin : g_cell
    csq_pkg::value_t below, above;
    if (g == 0) begin : g_first
      assign below = '0;
    end else begin : g_inner_lo
      assign below = cell_value[g-1];
    end
    if (g == csq_pkg::CAPACITY - 1) begin : g_last
      assign above = '0;
    end else begin : g_inner_hi
      assign above = cell_value[g+1];
    end
    csq_cell u_cell (
      .clk         (clk),
      .cmd         (cell_cmd[g]),
      .below_value (below),
      .above_value (above),
      .value       (cell_value[g])
    );
  end

  // list control state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cursor    <= '0;
      rejected  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        cursor   <= cursor_next;
        rejected <= rejected_next;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result fields straight from the registered state
  assign rsp.valid         = rsp_valid;
  assign rsp.has_current   = on_item;
  assign rsp.current_value = on_item ?
      csq_pkg::value_to_word(cell_value[cursor[csq_pkg::IDX_W-1:0]]) : '0;
  assign rsp.item_total    = csq_pkg::count_to_total(count);
  assign rsp.rejected      = rejected;

  // the list never grows past capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= csq_pkg::count_t'(csq_pkg::CAPACITY))
    else $error("item count above capacity");

  // an accepted insert or attach on a list with room grows it by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.kind == csq_pkg::K_INSERT || req.kind == csq_pkg::K_ATTACH) && !full)
    |=> (count == $past(count) + 1'b1) && !rejected)
    else $error("insert or attach did not grow the list");

  // a rejection is only ever reported with a full list
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rejected) |-> full)
    else $error("rejection reported with room left");

  // cursor never passes the item count
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= count || $past(accept && req.kind == csq_pkg::K_REMOVE))
    else $error("cursor beyond end of list");

endmodule

`default_nettype wire

// ===== hw/rtl/csq_cell.sv =====
// csq_cell: one slot of the ordered list, loads a new value or takes a neighbor's
// depends on csq_pkg for the value and command types
`default_nettype none

module csq_cell (
  input  wire logic               clk,
  input  wire csq_pkg::cell_cmd_t cmd,
  input  wire csq_pkg::value_t    below_value,
  input  wire csq_pkg::value_t    above_value,
  output csq_pkg::value_t         value
);

  // slot register, no reset: read only below the item count
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      csq_pkg::CELL_HOLD:       value <= value;
      csq_pkg::CELL_LOAD:       value <= cmd.load_value;
      csq_pkg::CELL_FROM_BELOW: value <= below_value;
      csq_pkg::CELL_FROM_ABOVE: value <= above_value;
      default:                  value <= value;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench of cursor_sequence_store_top, a bounded ordered list with a cursor
// a queue-fed driver and clocked monitors check every result against a local list predictor
// depends on csq_pkg, csq_req_if, csq_rsp_if and cursor_sequence_store_top
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 700;
  localparam int IDLE_PCT = 27;
  localparam int QUIET_FROM = 300;
  localparam int QUIET_TO = 450;

  typedef struct packed {
    logic [csq_pkg::KIND_W-1:0] kind;
    logic [csq_pkg::WORD_W-1:0] entry_value;
    logic                       hold_for_drain;
  } list_request_t;

  typedef struct packed {
    logic [csq_pkg::WORD_W-1:0]  current_value;
    logic                        has_current;
    logic [csq_pkg::TOTAL_W-1:0] item_total;
    logic                        rejected;
  } list_result_t;

  logic clk;
  logic rst;

  csq_req_if req_ch();
  csq_rsp_if rsp_ch();

  cursor_sequence_store_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  list_request_t pending_reqs[$];
  list_result_t  expected_results[$];

  // local copy of the list, its count and its cursor
  csq_pkg::value_t list_model[csq_pkg::CAPACITY];
  csq_pkg::count_t model_count;
  csq_pkg::count_t model_cursor;

  int  accepted_count;
  int  received_count;
  int  fail_count;
  int  cycle_count;
  int  stim_count;
  bit  req_taken;

  // apply one operation to the local list and queue the result it gives
  task automatic predict_list_op(input logic [csq_pkg::KIND_W-1:0] kind,
                                 input logic [csq_pkg::WORD_W-1:0] word);
    logic            on_item;
    logic            reject;
    csq_pkg::count_t pos;
    csq_pkg::value_t v;
    list_result_t    r;
    on_item = (model_cursor < model_count);
    reject  = 1'b0;
    v       = csq_pkg::value_t'(word);
    pos     = '0;
    case (csq_pkg::kind_t'(kind))
      csq_pkg::K_START: begin
        model_cursor = '0;
      end
      csq_pkg::K_ADVANCE: begin
        if (on_item) model_cursor = csq_pkg::count_t'(model_cursor + 1);
      end
      csq_pkg::K_INSERT, csq_pkg::K_ATTACH: begin
        if (model_count >= csq_pkg::CAPACITY) begin
          reject = 1'b1;
        end else begin
          if (csq_pkg::kind_t'(kind) == csq_pkg::K_INSERT)
            pos = on_item ? model_cursor : csq_pkg::count_t'(0);
          else
            pos = on_item ? csq_pkg::count_t'(model_cursor + 1) : model_count;
          for (int i = int'(model_count); i > int'(pos); i--) list_model[i] = list_model[i-1];
          list_model[pos] = v;
          model_count  = csq_pkg::count_t'(model_count + 1);
          model_cursor = pos;
        end
      end
      csq_pkg::K_REMOVE: begin
        if (on_item) begin
          for (int i = int'(model_cursor); i + 1 < int'(model_count); i++)
            list_model[i] = list_model[i+1];
          model_count = csq_pkg::count_t'(model_count - 1);
        end
      end
      default: begin
      end
    endcase
    if (model_cursor < model_count) begin
      r.current_value = csq_pkg::WORD_W'(list_model[model_cursor]);
      r.has_current   = 1'b1;
    end else begin
      r.current_value = '0;
      r.has_current   = 1'b0;
    end
    r.item_total = csq_pkg::TOTAL_W'(model_count);
    r.rejected   = reject;
    expected_results.push_back(r);
  endtask

  task automatic push_req(input logic [csq_pkg::KIND_W-1:0] kind,
                          input logic [csq_pkg::WORD_W-1:0] word,
                          input logic drain = 1'b0);
    list_request_t t;
    t.kind           = kind;
    t.entry_value    = word;
    t.hold_for_drain = drain;
    pending_reqs.push_back(t);
    stim_count++;
  endtask

  // random word with the extremes favored
  function automatic logic [csq_pkg::WORD_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return csq_pkg::WORD_W'($urandom);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // known values on every input from time zero
  initial begin
    rst               = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.kind        = '0;
    req_ch.entry_value = '0;
    rsp_ch.ready       = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // request driver, fed from the pending queue, changes at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      req_taken = 1'b0;
      if (pending_reqs.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (pending_reqs[0].hold_for_drain && expected_results.size() != 0) begin
        req_ch.valid <= 1'b0;
      end else if (!(accepted_count >= QUIET_FROM && accepted_count < QUIET_TO) &&
                   $urandom_range(99) < IDLE_PCT) begin
        req_ch.valid <= 1'b0;
      end else begin
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= pending_reqs[0].kind;
        req_ch.entry_value <= pending_reqs[0].entry_value;
        void'(pending_reqs.pop_front());
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (received_count >= QUIET_FROM && received_count < QUIET_TO)
      rsp_ch.ready <= 1'b1;
    else
      rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
  end

  // accepted request transaction: predict its result
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      predict_list_op(req_ch.kind, req_ch.entry_value);
      accepted_count++;
      req_taken = 1'b1;
    end
  end

  // accepted result transaction: compare against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      received_count++;
      if (expected_results.size() == 0) begin
        $error("result with no prediction waiting: current_value %h", rsp_ch.current_value);
        fail_count++;
      end else begin
        if (rsp_ch.current_value !== expected_results[0].current_value) begin
          $error("current_value: expected %h, actual %h",
                 expected_results[0].current_value, rsp_ch.current_value);
          fail_count++;
        end
        if (rsp_ch.has_current !== expected_results[0].has_current) begin
          $error("has_current: expected %b, actual %b",
                 expected_results[0].has_current, rsp_ch.has_current);
          fail_count++;
        end
        if (rsp_ch.item_total !== expected_results[0].item_total) begin
          $error("item_total: expected %0d, actual %0d",
                 expected_results[0].item_total, rsp_ch.item_total);
          fail_count++;
        end
        if (rsp_ch.rejected !== expected_results[0].rejected) begin
          $error("rejected: expected %b, actual %b",
                 expected_results[0].rejected, rsp_ch.rejected);
          fail_count++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int burst;
    int n;
    int sel;
    bit drain_mid_done;
    model_count    = '0;
    model_cursor   = '0;
    drain_mid_done = 1'b0;

    // directed: empty list, both ends, no-current cases, removes, unused codes
    push_req(csq_pkg::K_START, '0);
    push_req(csq_pkg::K_ADVANCE, '1);
    push_req(csq_pkg::K_REMOVE, '0);
    push_req(3'd5, '1);
    push_req(csq_pkg::K_INSERT, '0);                 // insert into empty list
    push_req(csq_pkg::K_ATTACH, 32'hFFFF_FFFF);      // attach after current
    push_req(csq_pkg::K_ADVANCE, '0);                // cursor off the end
    push_req(csq_pkg::K_ATTACH, 32'hA5A5_A5A5);      // no current: goes at the end
    push_req(csq_pkg::K_ADVANCE, '0);
    push_req(csq_pkg::K_INSERT, 32'h5A5A_5A5A);      // no current: goes at the front
    push_req(csq_pkg::K_START, '0);
    push_req(csq_pkg::K_ADVANCE, '0);
    push_req(csq_pkg::K_REMOVE, '0);                 // remove with a follower
    push_req(csq_pkg::K_ADVANCE, '0);
    push_req(csq_pkg::K_REMOVE, '0);                 // remove the last item
    push_req(csq_pkg::K_REMOVE, '1);                 // nothing current
    push_req(3'd6, 32'h8000_0001);
    push_req(3'd7, '1);

    // random bursts, mostly well-formed fill, walk and drain runs
    while (stim_count < RANDOM_ITEMS) begin
      burst = $urandom_range(9);
      if (!drain_mid_done && stim_count > 250) begin
        push_req(csq_pkg::K_START, '0, 1'b1);
        drain_mid_done = 1'b1;
      end
      if (burst <= 3) begin
        n = $urandom_range(20, 4);
        repeat (n) begin
          sel = $urandom_range(11);
          if (sel == 0) push_req(csq_pkg::K_ADVANCE, pick_word());
          else if (sel == 1) push_req(csq_pkg::K_START, pick_word());
          else if (sel < 7) push_req(csq_pkg::K_INSERT, pick_word());
          else push_req(csq_pkg::K_ATTACH, pick_word());
        end
      end else if (burst <= 5) begin
        push_req(csq_pkg::K_START, pick_word());
        n = $urandom_range(17);
        repeat (n) begin
          if ($urandom_range(7) == 0) push_req(csq_pkg::K_REMOVE, pick_word());
          else push_req(csq_pkg::K_ADVANCE, pick_word());
        end
      end else if (burst <= 7) begin
        if ($urandom_range(1) == 0) push_req(csq_pkg::K_START, pick_word());
        n = $urandom_range(10, 1);
        repeat (n) begin
          if ($urandom_range(4) == 0) push_req(csq_pkg::K_ADVANCE, pick_word());
          else push_req(csq_pkg::K_REMOVE, pick_word());
        end
      end else begin
        n = $urandom_range(8, 3);
        repeat (n) push_req(3'($urandom_range(7)), pick_word());
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_reqs.size() != 0 || req_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/csq_pkg.sv
hw/rtl/csq_req_if.sv
hw/rtl/csq_rsp_if.sv
hw/rtl/csq_cell.sv
hw/rtl/cursor_sequence_store_top.sv
tb/sv/tb_top.sv
